FILE: rtl/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion unit
package rmq_pkg;

  localparam int NUM_W = 17;
  localparam int MAG_W = 31;
  localparam int OUT_W = 16;
  localparam int LANES = 4;

  typedef enum logic [1:0] {
    PIV_X = 2'd0,
    PIV_Y = 2'd1,
    PIV_Z = 2'd2,
    PIV_W = 2'd3
  } pivot_t;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    pivot_t           pivot;
    num_t [LANES-1:0] num;
  } root_side_t;

  typedef struct packed {
    logic             ident;
    pivot_t           pivot;
    logic [LANES-1:0] neg;
    logic [MAG_W-1:0] piv_mag;
  } comp_side_t;

  typedef struct packed {
    logic                        ident;
    logic                        renorm;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } norm_side_t;

endpackage

FILE: rtl/rotation_matrix_to_quaternion_unit.sv
// rotation matrix to unit quaternion converter, fully pipelined
// throughput: one matrix per cycle; the depth is set by the two square-root
// pipelines and the two divider pipelines, each resolving one bit per stage
// reset: synchronous, clears only the valid bits; busy is high only during reset
// results leave on done for one cycle; the receiver cannot stall
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic               done,
  output logic signed [15:0] qx,
  output logic signed [15:0] qy,
  output logic signed [15:0] qz,
  output logic signed [15:0] qw,
  output logic               identity_fallback
);

  import rmq_pkg::*;

  localparam int ARG_W   = (FRAC_BITS > 17) ? FRAC_BITS + 2 : 19;
  localparam int RAD1_W  = ((ARG_W + FRAC_BITS + 1) / 2) * 2;
  localparam int ROOT1_W = RAD1_W / 2;
  localparam int HALF_W  = ROOT1_W - 1;
  localparam int NUM1_W  = NUM_W + FRAC_BITS;
  localparam int NUM2_W  = MAG_W + FRAC_BITS;
  localparam int NORM_W  = 64;
  localparam int ROOT2_W = NORM_W / 2;
  localparam int LATENCY = ROOT1_W + 90;

  localparam logic [NORM_W-1:0] ONE_SQ  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [NORM_W-1:0] EPS_SQ  = ONE_SQ / 64'd1000000;
  localparam logic [OUT_W-1:0]  ONE_OUT = (FRAC_BITS >= 15) ? 16'h7fff
                                          : OUT_W'(64'd1 << FRAC_BITS);
  localparam logic signed [ARG_W:0] ONE_ARG = (ARG_W + 1)'(64'd1 << FRAC_BITS);

  function automatic logic [OUT_W-1:0] sat16(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] t;
    t = -mag;
    if (neg) begin
      return (mag >= MAG_W'(32768)) ? 16'h8000 : t[OUT_W-1:0];
    end else begin
      return (mag >= MAG_W'(32767)) ? 16'h7fff : mag[OUT_W-1:0];
    end
  endfunction

  assign busy = rst;

  // input registers
  logic               a_valid;
  logic signed [15:0] a_m00, a_m01, a_m02, a_m10, a_m11, a_m12, a_m20, a_m21, a_m22;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start;
    end
    a_m00 <= m00;
    a_m01 <= m01;
    a_m02 <= m02;
    a_m10 <= m10;
    a_m11 <= m11;
    a_m12 <= m12;
    a_m20 <= m20;
    a_m21 <= m21;
    a_m22 <= m22;
  end

  // pivot selection and root argument
  logic signed [ARG_W:0] e00, e11, e22, trace, arg;
  logic                  sel1, sel2;
  logic signed [15:0]    diag_top;
  pivot_t                pivot;
  num_t                  d21_12, d02_20, d10_01, s01, s02, s12;
  logic [ARG_W-1:0]      arg_pos;
  root_side_t            b_side_next;

  assign e00      = (ARG_W + 1)'(a_m00);
  assign e11      = (ARG_W + 1)'(a_m11);
  assign e22      = (ARG_W + 1)'(a_m22);
  assign trace    = e00 + e11 + e22;
  assign sel1     = a_m11 > a_m00;
  assign diag_top = sel1 ? a_m11 : a_m00;
  assign sel2     = a_m22 > diag_top;

  assign d21_12 = num_t'(a_m21) - num_t'(a_m12);
  assign d02_20 = num_t'(a_m02) - num_t'(a_m20);
  assign d10_01 = num_t'(a_m10) - num_t'(a_m01);
  assign s01    = num_t'(a_m01) + num_t'(a_m10);
  assign s02    = num_t'(a_m02) + num_t'(a_m20);
  assign s12    = num_t'(a_m12) + num_t'(a_m21);

  always_comb begin
    if (trace > 0) begin
      pivot = PIV_W;
    end else if (sel2) begin
      pivot = PIV_Z;
    end else if (sel1) begin
      pivot = PIV_Y;
    end else begin
      pivot = PIV_X;
    end
    b_side_next.pivot = pivot;
    b_side_next.num   = '0;
    case (pivot)
      PIV_W: begin
        arg = trace + ONE_ARG;
        b_side_next.num[PIV_X] = d21_12;
        b_side_next.num[PIV_Y] = d02_20;
        b_side_next.num[PIV_Z] = d10_01;
      end
      PIV_X: begin
        arg = e00 - e11 - e22 + ONE_ARG;
        b_side_next.num[PIV_W] = d21_12;
        b_side_next.num[PIV_Y] = s01;
        b_side_next.num[PIV_Z] = s02;
      end
      PIV_Y: begin
        arg = e11 - e22 - e00 + ONE_ARG;
        b_side_next.num[PIV_W] = d02_20;
        b_side_next.num[PIV_Z] = s12;
        b_side_next.num[PIV_X] = s01;
      end
      PIV_Z: begin
        arg = e22 - e00 - e11 + ONE_ARG;
        b_side_next.num[PIV_W] = d10_01;
        b_side_next.num[PIV_X] = s02;
        b_side_next.num[PIV_Y] = s12;
      end
      default: begin
        arg = '0;
      end
    endcase
  end

  assign arg_pos = arg[ARG_W] ? '0 : arg[ARG_W-1:0];

  logic              b_valid;
  logic [RAD1_W-1:0] b_rad;
  root_side_t        b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_rad  <= RAD1_W'({arg_pos, {FRAC_BITS{1'b0}}});
    b_side <= b_side_next;
  end

  // first square root
  logic               r1_valid;
  logic [ROOT1_W-1:0] r1_root;
  root_side_t         r1_side;

  rmq_isqrt_pipe #(
    .RAD_W  (RAD1_W),
    .SIDE_W ($bits(root_side_t))
  ) u_sqrt_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .rad       (b_rad),
    .in_side   (b_side),
    .out_valid (r1_valid),
    .root      (r1_root),
    .out_side  (r1_side)
  );

  // divider operands
  logic [HALF_W-1:0]  half;
  logic [MAG_W-1:0]   piv_mag;
  comp_side_t         c_side_next;
  logic [LANES-1:0][NUM1_W-1:0] c_num_next;

  assign half = r1_root[ROOT1_W-1:1];

  generate
    if (HALF_W <= MAG_W) begin : g_half_fits
      assign piv_mag = MAG_W'(half);
    end else begin : g_half_clamp
      assign piv_mag = (|half[HALF_W-1:MAG_W]) ? '1 : half[MAG_W-1:0];
    end
  endgenerate

  always_comb begin
    logic [NUM_W-1:0] a;
    c_side_next.ident   = r1_root == '0;
    c_side_next.pivot   = r1_side.pivot;
    c_side_next.piv_mag = piv_mag;
    for (int l = 0; l < LANES; l++) begin
      a = r1_side.num[l][NUM_W-1] ? -r1_side.num[l] : r1_side.num[l];
      if (r1_side.pivot == pivot_t'(l)) begin
        c_num_next[l]        = '0;
        c_side_next.neg[l]   = 1'b0;
      end else begin
        c_num_next[l]        = {a, {FRAC_BITS{1'b0}}};
        c_side_next.neg[l]   = r1_side.num[l][NUM_W-1];
      end
    end
  end

  logic                         c_valid;
  logic [ROOT1_W:0]             c_den;
  logic [LANES-1:0][NUM1_W-1:0] c_num;
  comp_side_t                   c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= r1_valid;
    end
    c_den  <= {r1_root, 1'b0};
    c_num  <= c_num_next;
    c_side <= c_side_next;
  end

  // component divider
  logic                        q1_valid;
  logic [LANES-1:0][MAG_W-1:0] q1;
  comp_side_t                  q1_side;

  rmq_div_pipe #(
    .NUM_W  (NUM1_W),
    .DEN_W  (ROOT1_W + 1),
    .QUO_W  (MAG_W),
    .LANES  (LANES),
    .SIDE_W ($bits(comp_side_t))
  ) u_div_comp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .num       (c_num),
    .den       (c_den),
    .in_side   (c_side),
    .out_valid (q1_valid),
    .quo       (q1),
    .out_side  (q1_side)
  );

  // components, squares, norm
  norm_side_t d_side_next;

  always_comb begin
    d_side_next.ident  = q1_side.ident;
    d_side_next.renorm = 1'b0;
    d_side_next.neg    = q1_side.neg;
    for (int l = 0; l < LANES; l++) begin
      d_side_next.mag[l] = (q1_side.pivot == pivot_t'(l)) ? q1_side.piv_mag : q1[l];
    end
  end

  logic                              d_valid, e_valid, f_valid, g_valid, h_valid;
  norm_side_t                        d_side, e_side, f_side, g_side, h_side;
  logic [LANES-1:0][2*MAG_W-1:0]     e_sq;
  logic [2*MAG_W:0]                  f_sum0, f_sum1;
  logic [NORM_W-1:0]                 g_norm, h_norm;
  logic [NORM_W-1:0]                 dev;
  norm_side_t                        h_side_next;

  assign dev = (g_norm >= ONE_SQ) ? g_norm - ONE_SQ : ONE_SQ - g_norm;

  always_comb begin
    h_side_next        = g_side;
    h_side_next.ident  = g_side.ident || g_norm == '0 || g_norm < EPS_SQ;
    h_side_next.renorm = dev > EPS_SQ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
      h_valid <= 1'b0;
    end else begin
      d_valid <= q1_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
      h_valid <= g_valid;
    end
    d_side <= d_side_next;
    e_side <= d_side;
    for (int l = 0; l < LANES; l++) begin
      e_sq[l] <= d_side.mag[l] * d_side.mag[l];
    end
    f_side <= e_side;
    f_sum0 <= (2 * MAG_W + 1)'(e_sq[0]) + (2 * MAG_W + 1)'(e_sq[1]);
    f_sum1 <= (2 * MAG_W + 1)'(e_sq[2]) + (2 * MAG_W + 1)'(e_sq[3]);
    g_side <= f_side;
    g_norm <= NORM_W'(f_sum0) + NORM_W'(f_sum1);
    h_side <= h_side_next;
    h_norm <= g_norm;
  end

  // norm square root
  logic               r2_valid;
  logic [ROOT2_W-1:0] r2_root;
  norm_side_t         r2_side;

  rmq_isqrt_pipe #(
    .RAD_W  (NORM_W),
    .SIDE_W ($bits(norm_side_t))
  ) u_sqrt_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_valid),
    .rad       (h_norm),
    .in_side   (h_side),
    .out_valid (r2_valid),
    .root      (r2_root),
    .out_side  (r2_side)
  );

  // normalization divider
  logic [LANES-1:0][NUM2_W-1:0] n2;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      n2[l] = {r2_side.mag[l], {FRAC_BITS{1'b0}}};
    end
  end

  logic                        q2_valid;
  logic [LANES-1:0][OUT_W-1:0] q2;
  norm_side_t                  q2_side;

  rmq_div_pipe #(
    .NUM_W  (NUM2_W),
    .DEN_W  (ROOT2_W),
    .QUO_W  (OUT_W),
    .LANES  (LANES),
    .SIDE_W ($bits(norm_side_t))
  ) u_div_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r2_valid),
    .num       (n2),
    .den       (r2_root),
    .in_side   (r2_side),
    .out_valid (q2_valid),
    .quo       (q2),
    .out_side  (q2_side)
  );

  // output saturation and identity fallback
  logic [LANES-1:0][OUT_W-1:0] q_out_next;

  always_comb begin
    logic [MAG_W-1:0] m;
    for (int l = 0; l < LANES; l++) begin
      m = q2_side.renorm ? MAG_W'(q2[l]) : q2_side.mag[l];
      if (q2_side.ident) begin
        q_out_next[l] = (l == int'(PIV_W)) ? ONE_OUT : '0;
      end else begin
        q_out_next[l] = sat16(q2_side.neg[l], m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q2_valid;
    end
    qx                <= q_out_next[PIV_X];
    qy                <= q_out_next[PIV_Y];
    qz                <= q_out_next[PIV_Z];
    qw                <= q_out_next[PIV_W];
    identity_fallback <= q2_side.ident;
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transaction result missing after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted transaction");

  a_ident_vector: assert property (@(posedge clk) disable iff (rst)
    (done && identity_fallback) |-> (qx == 0 && qy == 0 && qz == 0 && qw == ONE_OUT))
    else $error("identity fallback with non-identity quaternion");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done || !$past(rst, LATENCY))
    else $error("result shortly after reset");

endmodule

FILE: rtl/rmq_isqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module rmq_isqrt_pipe #(
  parameter int RAD_W  = 34,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int STAGES = RAD_W / 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic              valid_q [STAGES];
  logic [ROOT_W-1:0] root_q  [STAGES];
  logic [ROOT_W-1:0] rem_q   [STAGES];
  logic [RAD_W-1:0]  rad_q   [STAGES];
  logic [SIDE_W-1:0] side_q  [STAGES];

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      logic              pv;
      logic [ROOT_W-1:0] pr;
      logic [ROOT_W-1:0] prem;
      logic [RAD_W-1:0]  prad;
      logic [SIDE_W-1:0] pside;
      logic [REM_W-1:0]  shifted;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_new;
      logic              fits;

      if (s == 0) begin : g_first
        assign pv    = in_valid;
        assign pr    = '0;
        assign prem  = '0;
        assign prad  = rad;
        assign pside = in_side;
      end else begin : g_next
        assign pv    = valid_q[s-1];
        assign pr    = root_q[s-1];
        assign prem  = rem_q[s-1];
        assign prad  = rad_q[s-1];
        assign pside = side_q[s-1];
      end

      assign shifted = {prem, prad[RAD_W-1-2*s -: 2]};
      assign trial   = {pr, 2'b01};
      assign fits    = shifted >= trial;
      assign rem_new = fits ? shifted - trial : shifted;

      always_ff @(posedge clk) begin
        if (rst) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= pv;
        end
        root_q[s] <= {pr[ROOT_W-2:0], fits};
        rem_q[s]  <= rem_new[ROOT_W-1:0];
        rad_q[s]  <= prad;
        side_q[s] <= pside;
      end
    end
  endgenerate

  assign out_valid = valid_q[STAGES-1];
  assign root      = root_q[STAGES-1];
  assign out_side  = side_q[STAGES-1];

endmodule

FILE: rtl/rmq_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module rmq_div_pipe #(
  parameter int NUM_W  = 31,
  parameter int DEN_W  = 18,
  parameter int QUO_W  = 31,
  parameter int LANES  = 4,
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]            den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][QUO_W-1:0] quo,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int REM_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
  localparam int STAGES = QUO_W + 1;

  logic              valid_q [STAGES];
  logic [DEN_W-1:0]  den_q   [STAGES];
  logic [REM_W-1:0]  rem_q   [STAGES][LANES];
  logic [QUO_W-1:0]  quo_q   [STAGES][LANES];
  logic [SIDE_W-1:0] side_q  [STAGES];

  logic [LANES-1:0]  ovf;
  logic [REM_W-1:0]  den_top;

  assign den_top = REM_W'({den, {QUO_W{1'b0}}});

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ovf[l] = REM_W'(num[l]) >= den_top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid;
    end
    den_q[0]  <= den;
    side_q[0] <= in_side;
    for (int l = 0; l < LANES; l++) begin
      rem_q[0][l] <= ovf[l] ? '0 : REM_W'(num[l]);
      quo_q[0][l] <= ovf[l] ? '1 : '0;
    end
  end

  genvar s;
  generate
    for (s = 1; s < STAGES; s++) begin : g_stage
      localparam int BIT = QUO_W - s;
      logic [REM_W-1:0] dsh;
      logic [LANES-1:0] fits;

      assign dsh = REM_W'(den_q[s-1]) << BIT;

      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          fits[l] = rem_q[s-1][l] >= dsh;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_q[s-1];
        end
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= fits[l] ? rem_q[s-1][l] - dsh : rem_q[s-1][l];
          quo_q[s][l] <= quo_q[s-1][l] | (QUO_W'(fits[l]) << BIT);
        end
      end
    end
  endgenerate

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = quo_q[STAGES-1][l];
    end
  end

  assign out_valid = valid_q[STAGES-1];
  assign out_side  = side_q[STAGES-1];

endmodule
